@@ sv/two_button_gesture_decoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-button gesture decoder
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_BUTTON_GESTURE_DECODER_CORE_ASSERT_SVH
`define TWO_BUTTON_GESTURE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication
`define TBGD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TBGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tbgd_pkg.sv @@
// ----------------------------------------------------------------------------
// tbgd_pkg
// Types and constants shared by the two-button gesture decoder.
// ----------------------------------------------------------------------------
package tbgd_pkg;

	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TAP_LIMIT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REP_FIRST  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REP_PERIOD = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DOUBLE_GAP = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_POWER_TIME = 3'd6;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd25;
	localparam logic [CFG_W-1:0] RST_TAP_LIMIT  = 16'd600;
	localparam logic [CFG_W-1:0] RST_HOLD_TIME  = 16'd1000;
	localparam logic [CFG_W-1:0] RST_REP_FIRST  = 16'd400;
	localparam logic [CFG_W-1:0] RST_REP_PERIOD = 16'd180;
	localparam logic [CFG_W-1:0] RST_DOUBLE_GAP = 16'd400;
	localparam logic [CFG_W-1:0] RST_POWER_TIME = 16'd5000;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] tap_limit;
		logic [CFG_W-1:0] hold_time;
		logic [CFG_W-1:0] repeat_first_delay;
		logic [CFG_W-1:0] repeat_period;
		logic [CFG_W-1:0] double_gap;
		logic [CFG_W-1:0] power_time;
	} cfg_t;

	// What one button lane found for the current poll
	typedef struct packed {
		logic press;
		logic tap;
		logic dbl;
		logic hold;
		logic rep;
		logic power;
		logic down;
		logic act;
	} lane_ev_t;

	typedef struct packed {
		logic              any_down;
		logic              top_tap;
		logic              top_double;
		logic              top_hold;
		logic              top_repeat;
		logic              bottom_tap;
		logic              bottom_double;
		logic              bottom_hold;
		logic              bottom_repeat;
		logic              power_off;
		logic              any_held;
		logic [TIME_W-1:0] last_activity;
	} res_t;

endpackage

@@ sv/two_button_gesture_decoder_core.sv @@
// ----------------------------------------------------------------------------
// two_button_gesture_decoder_core
// Debounce two buttons and report tap, double, hold, repeat and power-off.
// ----------------------------------------------------------------------------
// One poll (time stamp plus the raw levels of both buttons) is taken every
// clock cycle while in_ready is high; its result enters the output register
// or, on a stall, the skid stage. Each lane updates its whole state on each
// accepted poll. The skid stage lets a new poll be taken while a result
// still waits, so in_ready only drops after two results are stalled.
// The seven 16-bit registers sit on the APB port at byte addresses 0 to 24
// and must be written only while no poll is in flight.
module two_button_gesture_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// poll input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tbgd_pkg::TIME_W-1:0]   now_ms,
	input  logic                          top_pressed,
	input  logic                          bottom_pressed,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          any_down,
	output logic                          top_tap,
	output logic                          top_double,
	output logic                          top_hold,
	output logic                          top_repeat,
	output logic                          bottom_tap,
	output logic                          bottom_double,
	output logic                          bottom_hold,
	output logic                          bottom_repeat,
	output logic                          power_off,
	output logic                          any_held,
	output logic [tbgd_pkg::TIME_W-1:0]   last_activity,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbgd_pkg::ADDR_W-1:0]   paddr,
	input  logic [tbgd_pkg::DATA_W-1:0]   pwdata,
	output logic [tbgd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	tbgd_pkg::cfg_t     cfg_q;
	tbgd_pkg::lane_ev_t top_ev;
	tbgd_pkg::lane_ev_t bot_ev;
	tbgd_pkg::res_t     res;
	tbgd_pkg::res_t     out_q;
	tbgd_pkg::res_t     skid_q;
	logic               out_valid_q;
	logic               skid_valid_q;
	logic               in_xfer;
	logic               out_xfer;
	logic               wr_en;
	logic [tbgd_pkg::REG_IDX_W-1:0] reg_idx;
	logic [tbgd_pkg::CFG_W-1:0]     rd_val;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[tbgd_pkg::ADDR_W-1:2];
	assign wr_en    = psel && penable && pwrite;
	assign in_ready = !skid_valid_q;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time      <= tbgd_pkg::RST_DEBOUNCE;
			cfg_q.tap_limit          <= tbgd_pkg::RST_TAP_LIMIT;
			cfg_q.hold_time          <= tbgd_pkg::RST_HOLD_TIME;
			cfg_q.repeat_first_delay <= tbgd_pkg::RST_REP_FIRST;
			cfg_q.repeat_period      <= tbgd_pkg::RST_REP_PERIOD;
			cfg_q.double_gap         <= tbgd_pkg::RST_DOUBLE_GAP;
			cfg_q.power_time         <= tbgd_pkg::RST_POWER_TIME;
		end else if (wr_en) begin
			case (reg_idx)
				tbgd_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_time <= pwdata[tbgd_pkg::CFG_W-1:0];
				end
				tbgd_pkg::REG_TAP_LIMIT: begin
					cfg_q.tap_limit <= pwdata[tbgd_pkg::CFG_W-1:0];
				end
				tbgd_pkg::REG_HOLD_TIME: begin
					cfg_q.hold_time <= pwdata[tbgd_pkg::CFG_W-1:0];
				end
				tbgd_pkg::REG_REP_FIRST: begin
					cfg_q.repeat_first_delay <= pwdata[tbgd_pkg::CFG_W-1:0];
				end
				tbgd_pkg::REG_REP_PERIOD: begin
					cfg_q.repeat_period <= pwdata[tbgd_pkg::CFG_W-1:0];
				end
				tbgd_pkg::REG_DOUBLE_GAP: begin
					cfg_q.double_gap <= pwdata[tbgd_pkg::CFG_W-1:0];
				end
				tbgd_pkg::REG_POWER_TIME: begin
					cfg_q.power_time <= pwdata[tbgd_pkg::CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			tbgd_pkg::REG_DEBOUNCE:   rd_val = cfg_q.debounce_time;
			tbgd_pkg::REG_TAP_LIMIT:  rd_val = cfg_q.tap_limit;
			tbgd_pkg::REG_HOLD_TIME:  rd_val = cfg_q.hold_time;
			tbgd_pkg::REG_REP_FIRST:  rd_val = cfg_q.repeat_first_delay;
			tbgd_pkg::REG_REP_PERIOD: rd_val = cfg_q.repeat_period;
			tbgd_pkg::REG_DOUBLE_GAP: rd_val = cfg_q.double_gap;
			tbgd_pkg::REG_POWER_TIME: rd_val = cfg_q.power_time;
			default:                  rd_val = '0;
		endcase
		prdata = tbgd_pkg::DATA_W'(rd_val);
	end

	// Top lane first, bottom lane with power-off check
	tbgd_lane u_top_lane (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (in_xfer),
		.now      (now_ms),
		.raw      (top_pressed),
		.power_en (1'b0),
		.cfg      (cfg_q),
		.ev       (top_ev)
	);

	tbgd_lane u_bot_lane (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (in_xfer),
		.now      (now_ms),
		.raw      (bottom_pressed),
		.power_en (1'b1),
		.cfg      (cfg_q),
		.ev       (bot_ev)
	);

	tbgd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (in_xfer),
		.now    (now_ms),
		.top_ev (top_ev),
		.bot_ev (bot_ev),
		.res    (res)
	);

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_xfer) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_xfer) begin
			if (!out_valid_q || out_xfer) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_xfer) begin
				out_q <= skid_q;
			end
		end else if (in_xfer) begin
			if (!out_valid_q || out_xfer) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign any_down      = out_q.any_down;
	assign top_tap       = out_q.top_tap;
	assign top_double    = out_q.top_double;
	assign top_hold      = out_q.top_hold;
	assign top_repeat    = out_q.top_repeat;
	assign bottom_tap    = out_q.bottom_tap;
	assign bottom_double = out_q.bottom_double;
	assign bottom_hold   = out_q.bottom_hold;
	assign bottom_repeat = out_q.bottom_repeat;
	assign power_off     = out_q.power_off;
	assign any_held      = out_q.any_held;
	assign last_activity = out_q.last_activity;

endmodule

@@ sv/tbgd_lane.sv @@
// ----------------------------------------------------------------------------
// tbgd_lane
// Per-button debounce, tap, double, hold, repeat and power-off decoding.
// ----------------------------------------------------------------------------
module tbgd_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [tbgd_pkg::TIME_W-1:0] now,
	input  logic                        raw,
	input  logic                        power_en,
	input  tbgd_pkg::cfg_t              cfg,
	output tbgd_pkg::lane_ev_t          ev
);

	localparam int TW = tbgd_pkg::TIME_W;

	logic          down_q;
	logic [TW-1:0] press_start_q;
	logic [TW-1:0] last_edge_q;
	logic          hold_fired_q;
	logic [TW-1:0] next_rep_q;
	logic          consumed_q;
	logic [TW-1:0] last_tap_q;
	logic          tap_waiting_q;

	logic [TW-1:0] since_edge;
	logic [TW-1:0] held_old;
	logic [TW-1:0] gap_old;
	logic [TW-1:0] held_now;
	logic [TW-1:0] first_ext;
	logic          edge_ok;
	logic          press;
	logic          release_e;
	logic          rel_tap;
	logic          dbl;
	logic          down_now;
	logic          power;
	logic          hold;
	logic          rep_due;
	logic          rep;
	logic          tap;

	// Decode edges and events from the state before this poll
	always_comb begin
		since_edge = now - last_edge_q;
		held_old   = now - press_start_q;
		gap_old    = now - last_tap_q;
		first_ext  = TW'(cfg.repeat_first_delay);
		edge_ok    = (raw != down_q) && (since_edge > TW'(cfg.debounce_time));
		press      = edge_ok && raw;
		release_e  = edge_ok && !raw;
		rel_tap    = release_e && !consumed_q && (held_old <= TW'(cfg.tap_limit));
		dbl        = rel_tap && tap_waiting_q && (gap_old <= TW'(cfg.double_gap));
		down_now   = edge_ok ? raw : down_q;
		held_now   = press ? '0 : held_old;
		power      = power_en && down_now && (held_now >= TW'(cfg.power_time));
		hold       = down_now && !power && (press || !hold_fired_q) &&
		             (held_now >= TW'(cfg.hold_time));
		// on a fresh press the deadline is now + first delay
		rep_due    = press ? (cfg.repeat_first_delay == '0) : (now >= next_rep_q);
		rep        = down_now && !power && (held_now >= first_ext) && rep_due;
		tap        = tap_waiting_q && !down_now && !rel_tap &&
		             (gap_old > TW'(cfg.double_gap));
	end

	always_comb begin
		ev.press = press;
		ev.tap   = tap;
		ev.dbl   = dbl;
		ev.hold  = hold;
		ev.rep   = rep;
		ev.power = power;
		ev.down  = down_now;
		ev.act   = edge_ok || down_now;
	end

	// Advance the button state on each accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q        <= 1'b0;
			press_start_q <= '0;
			last_edge_q   <= '0;
			hold_fired_q  <= 1'b0;
			next_rep_q    <= '0;
			consumed_q    <= 1'b0;
			last_tap_q    <= '0;
			tap_waiting_q <= 1'b0;
		end else if (upd) begin
			if (edge_ok) begin
				last_edge_q <= now;
				down_q      <= raw;
			end
			if (press) begin
				press_start_q <= now;
			end
			if (hold) begin
				hold_fired_q <= 1'b1;
			end else if (press) begin
				hold_fired_q <= 1'b0;
			end
			if (rep) begin
				next_rep_q <= now + TW'(cfg.repeat_period);
			end else if (press) begin
				next_rep_q <= now + first_ext;
			end
			if (power || hold || rep) begin
				consumed_q <= 1'b1;
			end else if (press) begin
				consumed_q <= 1'b0;
			end
			if (dbl) begin
				tap_waiting_q <= 1'b0;
			end else if (rel_tap) begin
				tap_waiting_q <= 1'b1;
			end else if (tap) begin
				tap_waiting_q <= 1'b0;
			end
			if (rel_tap && !dbl) begin
				last_tap_q <= now;
			end
		end
	end

endmodule

@@ sv/tbgd_merge.sv @@
// ----------------------------------------------------------------------------
// tbgd_merge
// Combine both lanes into one result and keep the last-activity time.
// ----------------------------------------------------------------------------
module tbgd_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [tbgd_pkg::TIME_W-1:0] now,
	input  tbgd_pkg::lane_ev_t          top_ev,
	input  tbgd_pkg::lane_ev_t          bot_ev,
	output tbgd_pkg::res_t              res
);

	logic [tbgd_pkg::TIME_W-1:0] activity_q;
	logic                        act_hit;

	assign act_hit = top_ev.act || bot_ev.act;

	// Gather the flags of both buttons
	always_comb begin
		res.any_down      = top_ev.press || bot_ev.press;
		res.top_tap       = top_ev.tap;
		res.top_double    = top_ev.dbl;
		res.top_hold      = top_ev.hold;
		res.top_repeat    = top_ev.rep;
		res.bottom_tap    = bot_ev.tap;
		res.bottom_double = bot_ev.dbl;
		res.bottom_hold   = bot_ev.hold;
		res.bottom_repeat = bot_ev.rep;
		res.power_off     = bot_ev.power;
		res.any_held      = top_ev.down || bot_ev.down;
		res.last_activity = act_hit ? now : activity_q;
	end

	// Hold the time of the last edge or held poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activity_q <= '0;
		end else if (upd && act_hit) begin
			activity_q <= now;
		end
	end

endmodule

@@ sv/tbgd_checker.sv @@
// ----------------------------------------------------------------------------
// tbgd_checker
// Port-level checks on the gesture decoder results, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_button_gesture_decoder_core_assert.svh"

module tbgd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        any_down,
	input logic                        top_tap,
	input logic                        top_double,
	input logic                        top_hold,
	input logic                        top_repeat,
	input logic                        bottom_tap,
	input logic                        bottom_double,
	input logic                        bottom_hold,
	input logic                        bottom_repeat,
	input logic                        power_off,
	input logic                        any_held,
	input logic [tbgd_pkg::TIME_W-1:0] last_activity
);

	// A stalled result keeps its time stamp
	`TBGD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, $stable(last_activity), "stalled result changed")

	// Power-off ends the bottom step: no other bottom gesture
	`TBGD_ASSERT_IMPL(a_power_alone, out_valid && power_off, !bottom_hold && !bottom_repeat && !bottom_tap && !bottom_double, "bottom gesture with power off")

	// A single and a double tap never come from the same poll
	`TBGD_ASSERT_IMPL(a_tap_excl, out_valid, !(top_tap && top_double) && !(bottom_tap && bottom_double), "tap and double together")

	// Press, hold, repeat and power-off need a button down
	`TBGD_ASSERT_IMPL(a_held, out_valid && (any_down || top_hold || top_repeat || bottom_hold || bottom_repeat || power_off), any_held, "press event without held button")

endmodule

bind two_button_gesture_decoder_core tbgd_checker u_tbgd_checker (.*);
